/* rtl/core/iirs_pkg.sv */
// shared constants, codes, types and the back sequencer states of the integral image block
package iirs_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int DIM_W      = 7;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int ENTRY_W    = 20;
    localparam int VALUE_W    = 21;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [DIM_W-1:0] dim_t;

    localparam dim_t DIM_RESET = 7'd64;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    // effective image size and a pulse that restarts the load position
    typedef struct packed
    {
        dim_t width;
        dim_t height;
        logic restart;
    } cfg_t;

    // one classified job; coordinates are already in range
    // load: pair 1 is the previous column (x-1,y),(x-1,y-1), c2/r2 the write position
    // query: pair 1 is (x2,y2),(x1-1,y1-1), pair 2 is (x1-1,y2),(x2,y1-1)
    typedef struct packed
    {
        logic               is_query;
        logic [PIX_W-1:0]   pixel;
        logic               frame_done;
        dim_t               c0;
        dim_t               r0;
        dim_t               c1;
        dim_t               r1;
        dim_t               c2;
        dim_t               r2;
        dim_t               c3;
        dim_t               r3;
    } job_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0]
    {
        BK_IDLE  = 2'd0,
        BK_PAIR2 = 2'd1,
        BK_CALC  = 2'd2
    } back_state_t;

endpackage

/* rtl/core/iirs_if.sv */
// valid/ready channel interfaces for command items and result items
interface iirs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [iirs_pkg::PIX_W-1:0]          pixel;
    logic signed [iirs_pkg::COORD_W-1:0] left_col;
    logic signed [iirs_pkg::COORD_W-1:0] top_row;
    logic signed [iirs_pkg::COORD_W-1:0] right_col;
    logic signed [iirs_pkg::COORD_W-1:0] bottom_row;

    modport source
    (
        output valid, command, pixel, left_col, top_row, right_col, bottom_row,
        input  ready
    );

    modport sink
    (
        input  valid, command, pixel, left_col, top_row, right_col, bottom_row,
        output ready
    );
endinterface

interface iirs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [iirs_pkg::VALUE_W-1:0] value;
    logic                                frame_done;

    modport source
    (
        output valid, value, frame_done,
        input  ready
    );

    modport sink
    (
        input  valid, value, frame_done,
        output ready
    );
endinterface

/* rtl/core/integral_image_region_sum.sv */
// top level of the summed-area table builder with rectangle-sum queries
//
//  channel   dir   handshake               payload
//  req       in    req.valid / req.ready   command, pixel, left_col, top_row,
//                                          right_col, bottom_row
//  rsp       out   rsp.valid / rsp.ready   value, frame_done
//  apb       in    psel, penable, pwrite   paddr, pwdata -> prdata (pready tied high)
//
//  sequencing: the back sequencer handles a load by reading the previous column pair,
//    then adding and writing, and a query by reading two corner pairs through the
//    table's two read ports, then combining; the front takes an item every cycle
//    while the job queue has room
//  reset: rst_n clears control state at once; the table is not cleared and holds
//    meaningful data only once a whole frame has been loaded
//  stalls: a held result parks in the output register; the front keeps filling the
//    queue until it is full, then drops req.ready
module integral_image_region_sum
#(
    parameter int MAX_WIDTH  = iirs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iirs_pkg::DEF_MAX_HEIGHT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    iirs_in_if.sink                             req,
    iirs_out_if.source                          rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iirs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [iirs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [iirs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int DW = iirs_pkg::DIM_W;
    localparam int PW = iirs_pkg::CFG_DATA_W;

    // raw register values as written, read back unchanged
    iirs_pkg::dim_t          width_reg;
    iirs_pkg::dim_t          width_next;
    iirs_pkg::dim_t          height_reg;
    iirs_pkg::dim_t          height_next;

    logic                    cfg_write;
    iirs_pkg::reg_index_t    reg_sel;
    iirs_pkg::cfg_t          cfg;

    logic                    push;
    logic                    pop;
    iirs_pkg::job_t          job_in;
    iirs_pkg::job_t          job_head;
    iirs_pkg::queue_status_t q_status;
    logic                    back_busy;
    logic                    at_origin;

    // effective dimension: saturate the register into 2..max
    function automatic iirs_pkg::dim_t eff_dim(input iirs_pkg::dim_t r, input int maxv);
        iirs_pkg::dim_t d;
        if (r < DW'(2))
        begin
            d = DW'(2);
        end
        else if (int'(r) > maxv)
        begin
            d = DW'(maxv);
        end
        else
        begin
            d = r;
        end
        return d;
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = iirs_pkg::reg_index_t'(paddr[iirs_pkg::CFG_ADDR_W-1]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                iirs_pkg::REG_WIDTH:  width_next  = pwdata[DW-1:0];
                iirs_pkg::REG_HEIGHT: height_next = pwdata[DW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            iirs_pkg::REG_WIDTH:  prdata = PW'(width_reg);
            iirs_pkg::REG_HEIGHT: prdata = PW'(height_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= iirs_pkg::DIM_RESET;
            height_reg <= iirs_pkg::DIM_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // any register write also starts a new frame at the origin
    always_comb
    begin
        cfg.width   = eff_dim(width_reg, MAX_WIDTH);
        cfg.height  = eff_dim(height_reg, MAX_HEIGHT);
        cfg.restart = cfg_write;
    end

    // front: position tracking and corner clamping
    iirs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .q_full    (q_status.full),
        .push      (push),
        .job       (job_in),
        .at_origin (at_origin)
    );

    // decouples acceptance from the table sequencer
    iirs_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (job_in),
        .pop    (pop),
        .dout   (job_head),
        .status (q_status)
    );

    // back: table reads, arithmetic, table write and result register
    iirs_back
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (job_head),
        .q_empty (q_status.empty),
        .pop     (pop),
        .rsp     (rsp),
        .busy    (back_busy)
    );

    // an accepted item is held somewhere: queue, sequencer or output register
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !q_status.empty || back_busy || rsp.valid)
        else $error("accepted item not held in queue, sequencer or output");

    // a register write returns the load position to the origin
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> at_origin)
        else $error("load position not at origin after register write");

endmodule

/* rtl/core/iirs_front.sv */
// front end: accepts items, tracks the load position, clamps query corners, builds jobs
module iirs_front
(
    input  logic            clk,
    input  logic            rst_n,
    iirs_in_if.sink         req,
    input  iirs_pkg::cfg_t  cfg,
    input  logic            q_full,
    output logic            push,
    output iirs_pkg::job_t  job,
    output logic            at_origin
);

    localparam int DW = iirs_pkg::DIM_W;

    iirs_pkg::dim_t col_reg;
    iirs_pkg::dim_t col_next;
    iirs_pkg::dim_t row_reg;
    iirs_pkg::dim_t row_next;

    logic           accept;
    logic           wrapped;
    iirs_pkg::dim_t x;
    iirs_pkg::dim_t y;
    iirs_pkg::dim_t row_inc;
    iirs_pkg::dim_t col_inc;
    logic           row_end;
    logic           col_end;
    iirs_pkg::dim_t qx1;
    iirs_pkg::dim_t qy1;
    iirs_pkg::dim_t qx2;
    iirs_pkg::dim_t qy2;

    function automatic iirs_pkg::dim_t clamp_coord
    (
        input logic signed [iirs_pkg::COORD_W-1:0] v,
        input iirs_pkg::dim_t                      dim
    );
        iirs_pkg::dim_t c;
        if (v <= 0)
        begin
            c = DW'(1);
        end
        else
        begin
            c = v[DW-1:0];
        end
        if (c >= dim)
        begin
            c = dim - DW'(1);
        end
        return c;
    endfunction

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign push      = accept;
    assign at_origin = (col_reg == '0) && (row_reg == '0);

    // position and its successor
    always_comb
    begin
        wrapped = (col_reg >= cfg.width) || (row_reg >= cfg.height);
        x       = wrapped ? '0 : col_reg;
        y       = wrapped ? '0 : row_reg;
        row_inc = y + DW'(1);
        col_inc = x + DW'(1);
        row_end = row_inc >= cfg.height;
        col_end = col_inc >= cfg.width;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && (req.command == iirs_pkg::CMD_LOAD))
        begin
            row_next = row_end ? '0 : row_inc;
            col_next = row_end ? (col_end ? '0 : col_inc) : x;
        end
    end

    always_comb
    begin
        qx1 = clamp_coord(req.left_col, cfg.width);
        qy1 = clamp_coord(req.top_row, cfg.height);
        qx2 = clamp_coord(req.right_col, cfg.width);
        qy2 = clamp_coord(req.bottom_row, cfg.height);
    end

    always_comb
    begin
        job.pixel = req.pixel;
        unique case (req.command)
            iirs_pkg::CMD_QUERY:
            begin
                job.is_query   = 1'b1;
                job.frame_done = 1'b0;
                job.c0         = qx2;
                job.r0         = qy2;
                job.c1         = qx1 - DW'(1);
                job.r1         = qy1 - DW'(1);
                job.c2         = qx1 - DW'(1);
                job.r2         = qy2;
                job.c3         = qx2;
                job.r3         = qy1 - DW'(1);
            end
            iirs_pkg::CMD_LOAD:
            begin
                // x-1 or y-1 below zero wraps and is masked in the back end
                job.is_query   = 1'b0;
                job.frame_done = row_end && col_end;
                job.c0         = x - DW'(1);
                job.r0         = y;
                job.c1         = x - DW'(1);
                job.r1         = y - DW'(1);
                job.c2         = x;
                job.r2         = y;
                job.c3         = x;
                job.r3         = y;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/core/iirs_queue.sv */
// short job queue between the front and back ends
module iirs_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  iirs_pkg::job_t          din,
    input  logic                    pop,
    output iirs_pkg::job_t          dout,
    output iirs_pkg::queue_status_t status
);

    localparam int DEPTH = iirs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iirs_pkg::job_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign dout         = entries[rd_ptr_reg];
    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= din;
        end
    end

endmodule

/* rtl/core/iirs_back.sv */
// back end: table memory, read sequencer, entry and rectangle arithmetic, output register
module iirs_back
#(
    parameter int MAX_WIDTH  = iirs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iirs_pkg::DEF_MAX_HEIGHT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  iirs_pkg::job_t head,
    input  logic           q_empty,
    output logic           pop,
    iirs_out_if.source     rsp,
    output logic           busy
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = MAX_WIDTH * (1 << ROW_W);
    localparam int EW     = iirs_pkg::ENTRY_W;
    localparam int VW     = iirs_pkg::VALUE_W;

    iirs_pkg::back_state_t state_reg;
    iirs_pkg::back_state_t state_next;

    logic [EW-1:0]     mem [DEPTH];
    iirs_pkg::job_t    job_reg;
    logic [EW-1:0]     d0_reg;
    logic [EW-1:0]     d1_reg;
    logic [VW-1:0]     partial_reg;
    logic [EW-1:0]     prev_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [VW-1:0]     out_value_reg;
    logic              out_done_reg;

    logic              out_free;
    logic              rd_en;
    logic              wr_en;
    logic              fire;
    logic [ADDR_W-1:0] rd_a0;
    logic [ADDR_W-1:0] rd_a1;
    logic [ADDR_W-1:0] wr_addr;
    logic              zero_col;
    logic              zero_row;
    logic [EW-1:0]     up;
    logic [EW-1:0]     left;
    logic [EW-1:0]     diag;
    logic [EW-1:0]     entry;
    logic [VW-1:0]     qsum;

    function automatic logic [ADDR_W-1:0] addr_of
    (
        input iirs_pkg::dim_t c,
        input iirs_pkg::dim_t r
    );
        return {COL_W'(c), ROW_W'(r)};
    endfunction

    assign out_free = !out_valid_reg || rsp.ready;
    assign busy     = state_reg != iirs_pkg::BK_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iirs_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = head.is_query ? iirs_pkg::BK_PAIR2 : iirs_pkg::BK_CALC;
                end
            end
            iirs_pkg::BK_PAIR2:
            begin
                state_next = iirs_pkg::BK_CALC;
            end
            iirs_pkg::BK_CALC:
            begin
                if (out_free)
                begin
                    state_next = iirs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = iirs_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop   = 1'b0;
        rd_en = 1'b0;
        fire  = 1'b0;
        wr_en = 1'b0;
        rd_a0 = addr_of(job_reg.c2, job_reg.r2);
        rd_a1 = addr_of(job_reg.c3, job_reg.r3);
        unique case (state_reg)
            iirs_pkg::BK_IDLE:
            begin
                pop   = !q_empty;
                rd_en = !q_empty;
                rd_a0 = addr_of(head.c0, head.r0);
                rd_a1 = addr_of(head.c1, head.r1);
            end
            iirs_pkg::BK_PAIR2:
            begin
                rd_en = 1'b1;
            end
            iirs_pkg::BK_CALC:
            begin
                fire  = out_free;
                wr_en = out_free && !job_reg.is_query;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // edges of the image read as zero
    always_comb
    begin
        zero_col = job_reg.c2 == '0;
        zero_row = job_reg.r2 == '0;
        up       = zero_row ? '0 : prev_reg;
        left     = zero_col ? '0 : d0_reg;
        diag     = (zero_col || zero_row) ? '0 : d1_reg;
        entry    = up + left + EW'(job_reg.pixel) - diag;
        qsum     = partial_reg - VW'(d0_reg) - VW'(d1_reg);
        wr_addr  = addr_of(job_reg.c2, job_reg.r2);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iirs_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (state_reg == iirs_pkg::BK_PAIR2)
        begin
            partial_reg <= VW'(d0_reg) + VW'(d1_reg);
        end
        if (wr_en)
        begin
            prev_reg <= entry;
        end
        if (fire)
        begin
            out_value_reg <= job_reg.is_query ? qsum : VW'(entry);
            out_done_reg  <= !job_reg.is_query && job_reg.frame_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= entry;
        end
        if (rd_en)
        begin
            d0_reg <= mem[rd_a0];
            d1_reg <= mem[rd_a1];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.value      = $signed(out_value_reg);
    assign rsp.frame_done = out_done_reg;

endmodule

/* tb/integral_image_region_sum_test.sv */
// self-checking testbench for the integral image builder with rectangle-sum queries
`timescale 1ns / 100ps

module integral_image_region_sum_test;

    // no item moving in either direction for this many cycles ends the run
    localparam int STALL_LIMIT = 1000;

    // one command item as it is queued for the driver
    typedef struct packed
    {
        logic                         command;
        logic [iirs_pkg::PIX_W-1:0]   pixel;
        logic [iirs_pkg::COORD_W-1:0] left_col;
        logic [iirs_pkg::COORD_W-1:0] top_row;
        logic [iirs_pkg::COORD_W-1:0] right_col;
        logic [iirs_pkg::COORD_W-1:0] bottom_row;
    } pixel_cmd_t;

    // one result item: table entry on a load, rectangle sum on a query
    typedef struct packed
    {
        logic [iirs_pkg::VALUE_W-1:0] value;
        logic                         frame_done;
    } sum_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [iirs_pkg::CFG_ADDR_W-1:0] paddr;
    logic [iirs_pkg::CFG_DATA_W-1:0] pwdata;
    logic [iirs_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    iirs_in_if  req_ch ();
    iirs_out_if rsp_ch ();

    integral_image_region_sum DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the block: summed-area table, load position, size registers
    // ------------------------------------------------------------------
    logic [iirs_pkg::ENTRY_W-1:0] sat_mem
        [0:iirs_pkg::DEF_MAX_WIDTH*iirs_pkg::DEF_MAX_HEIGHT-1];
    iirs_pkg::dim_t     width_reg  = iirs_pkg::DIM_RESET;
    iirs_pkg::dim_t     height_reg = iirs_pkg::DIM_RESET;
    int                 pos_col    = 0;
    int                 pos_row    = 0;

    // stimulus and checking bookkeeping
    pixel_cmd_t  pending [$];          // items waiting for the driver
    sum_result_t expected_sums [$];    // predicted results, oldest first
    int          pushed       = 0;     // items handed to the driver so far
    int          results_seen = 0;     // result items taken from the block
    int          errors       = 0;
    int          idle_pct     = 0;     // chance in percent that an idle burst starts
    int          send_gap     = 0;
    int          hold_gap     = 0;
    int          quiet_cycles = 0;

    // register value to the size actually used: saturates into 2..top
    function automatic int span(iirs_pkg::dim_t raw, int top);
        if (raw < 2)
            return 2;
        if (raw > top)
            return top;
        return int'(raw);
    endfunction

    // table entry, with any index of -1 reading as zero
    function automatic int corner(int c, int r);
        if (c < 0 || r < 0)
            return 0;
        return int'(sat_mem[c*iirs_pkg::DEF_MAX_HEIGHT + r]);
    endfunction

    // query coordinate into 1..dim-1
    function automatic int fold(logic [iirs_pkg::COORD_W-1:0] raw, int dim);
        int v;
        v = int'($signed(raw));
        if (v <= 0)
            v = 1;
        if (v >= dim)
            v = dim - 1;
        return v;
    endfunction

    // advances the shadow state by one item and returns the result it causes
    function automatic sum_result_t predict_sum(pixel_cmd_t it);
        sum_result_t                  res;
        int                           w;
        int                           h;
        int                           x1;
        int                           y1;
        int                           x2;
        int                           y2;
        int                           s;
        logic [iirs_pkg::ENTRY_W-1:0] e;
        w = span(width_reg, iirs_pkg::DEF_MAX_WIDTH);
        h = span(height_reg, iirs_pkg::DEF_MAX_HEIGHT);
        res.frame_done = 1'b0;
        if (it.command == iirs_pkg::CMD_LOAD)
        begin
            if (pos_col >= w || pos_row >= h)
            begin
                pos_col = 0;
                pos_row = 0;
            end
            s = corner(pos_col, pos_row - 1) + corner(pos_col - 1, pos_row)
                + int'(it.pixel) - corner(pos_col - 1, pos_row - 1);
            e = s[iirs_pkg::ENTRY_W-1:0];
            sat_mem[pos_col*iirs_pkg::DEF_MAX_HEIGHT + pos_row] = e;
            pos_row++;
            if (pos_row >= h)
            begin
                pos_row = 0;
                pos_col++;
                // last pixel of the frame: wrap and flag it
                if (pos_col >= w)
                begin
                    pos_col = 0;
                    res.frame_done = 1'b1;
                end
            end
            res.value = {1'b0, e};
        end
        else
        begin
            x1 = fold(it.left_col, w);
            y1 = fold(it.top_row, h);
            x2 = fold(it.right_col, w);
            y2 = fold(it.bottom_row, h);
            // reversed corners give a negative sum
            s = corner(x2, y2) + corner(x1 - 1, y1 - 1)
                - corner(x1 - 1, y2) - corner(x2, y1 - 1);
            res.value = s[iirs_pkg::VALUE_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [iirs_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return iirs_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mix of wild values, in-range values and values right at the clamp edges
    function automatic logic [iirs_pkg::COORD_W-1:0] pick_coord(int dim);
        case ($urandom_range(0, 3))
            0: return iirs_pkg::COORD_W'($urandom_range(0, 255));
            1: return iirs_pkg::COORD_W'($urandom_range(0, dim));
            2:
            begin
                case ($urandom_range(0, 6))
                    0:       return iirs_pkg::COORD_W'(-128);
                    1:       return iirs_pkg::COORD_W'(-1);
                    2:       return iirs_pkg::COORD_W'(0);
                    3:       return iirs_pkg::COORD_W'(1);
                    4:       return iirs_pkg::COORD_W'(dim - 1);
                    5:       return iirs_pkg::COORD_W'(dim);
                    default: return iirs_pkg::COORD_W'(127);
                endcase
            end
            default: return iirs_pkg::COORD_W'($urandom_range(1, dim - 1));
        endcase
    endfunction

    // a load carries random coordinates that the block must ignore
    function automatic void push_load(logic [iirs_pkg::PIX_W-1:0] pix);
        pixel_cmd_t it;
        it.command    = iirs_pkg::CMD_LOAD;
        it.pixel      = pix;
        it.left_col   = iirs_pkg::COORD_W'($urandom_range(0, 255));
        it.top_row    = iirs_pkg::COORD_W'($urandom_range(0, 255));
        it.right_col  = iirs_pkg::COORD_W'($urandom_range(0, 255));
        it.bottom_row = iirs_pkg::COORD_W'($urandom_range(0, 255));
        pending.insert(pending.size(), it);
        pushed++;
    endfunction

    // a query carries a random pixel that the block must ignore
    function automatic void push_query(int l, int t, int r, int b);
        pixel_cmd_t it;
        it.command    = iirs_pkg::CMD_QUERY;
        it.pixel      = iirs_pkg::PIX_W'($urandom_range(0, 255));
        it.left_col   = iirs_pkg::COORD_W'(l);
        it.top_row    = iirs_pkg::COORD_W'(t);
        it.right_col  = iirs_pkg::COORD_W'(r);
        it.bottom_row = iirs_pkg::COORD_W'(b);
        pending.insert(pending.size(), it);
        pushed++;
    endfunction

    // queries only once a whole frame is in the table, loads keep going and wrap
    function automatic void push_mix(int n, int w, int h);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 6)
                push_query(int'(pick_coord(w)), int'(pick_coord(h)),
                           int'(pick_coord(w)), int'(pick_coord(h)));
            else
                push_load(pick_pixel());
        end
    endfunction

    // every item gives exactly one result, so idle means all results are back
    task automatic drain();
        while (results_seen < pushed)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the write lands at the access edge
    task automatic write_reg(iirs_pkg::reg_index_t idx, iirs_pkg::dim_t raw);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= iirs_pkg::CFG_DATA_W'(raw);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == iirs_pkg::REG_WIDTH)
            width_reg = raw;
        else
            height_reg = raw;
        // any register write restarts the frame
        pos_col = 0;
        pos_row = 0;
    endtask

    // new size, one whole frame of loads, then a random mix of queries and loads
    task automatic run_phase(iirs_pkg::dim_t raw_w, iirs_pkg::dim_t raw_h, int n_mix,
                             int pct);
        int w;
        int h;
        bit bright;
        idle_pct = pct;
        write_reg(iirs_pkg::REG_WIDTH, raw_w);
        write_reg(iirs_pkg::REG_HEIGHT, raw_h);
        w = span(raw_w, iirs_pkg::DEF_MAX_WIDTH);
        h = span(raw_h, iirs_pkg::DEF_MAX_HEIGHT);
        // now and then a saturated frame pushes the sums toward their top
        bright = ($urandom_range(0, 3) == 0);
        repeat (w*h)
            push_load(bright ? iirs_pkg::PIX_W'(255) : pick_pixel());
        push_mix(n_mix, w, h);
        drain();
    endtask

    // ------------------------------------------------------------------
    // driver: feeds queued items, with random idle bursts
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_cmd_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap     <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_gap     <= $urandom_range(0, 16);
                req_ch.valid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                nxt = pending.pop_front();
                req_ch.command    <= nxt.command;
                req_ch.pixel      <= nxt.pixel;
                req_ch.left_col   <= nxt.left_col;
                req_ch.top_row    <= nxt.top_row;
                req_ch.right_col  <= nxt.right_col;
                req_ch.bottom_row <= nxt.bottom_row;
                req_ch.valid      <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result side stalls in random bursts as well
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_gap     <= 0;
        end
        else if (hold_gap != 0)
        begin
            hold_gap     <= hold_gap - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            hold_gap     <= $urandom_range(0, 16);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // monitor: predict on every accepted item, check every accepted result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_cmd_t  seen;
        sum_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen.command    = req_ch.command;
                seen.pixel      = req_ch.pixel;
                seen.left_col   = req_ch.left_col;
                seen.top_row    = req_ch.top_row;
                seen.right_col  = req_ch.right_col;
                seen.bottom_row = req_ch.bottom_row;
                expected_sums.insert(expected_sums.size(), predict_sum(seen));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: result with nothing expected: value %0d frame_done %0b",
                             $time, $signed(rsp_ch.value), rsp_ch.frame_done);
                    errors++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (rsp_ch.value !== want.value)
                    begin
                        $display("%0t: value mismatch: expected %0d actual %0d",
                                 $time, $signed(want.value), $signed(rsp_ch.value));
                        errors++;
                    end
                    if (rsp_ch.frame_done !== want.frame_done)
                    begin
                        $display("%0t: frame_done mismatch: expected %0b actual %0b",
                                 $time, want.frame_done, rsp_ch.frame_done);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles in which nothing moves at all
    always @(posedge clk)
    begin
        if (!rst_n || psel || (req_ch.valid && req_ch.ready)
            || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = iirs_pkg::CMD_LOAD;
        req_ch.pixel      = '0;
        req_ch.left_col   = '0;
        req_ch.top_row    = '0;
        req_ch.right_col  = '0;
        req_ch.bottom_row = '0;
        rsp_ch.ready      = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset size 64x64: loads run into the second column, no frame completes,
        // so no query is allowed here
        idle_pct = 15;
        repeat (66)
            push_load(pick_pixel());
        drain();

        // smallest image, directed: pixel extremes, then corners at every clamp edge
        write_reg(iirs_pkg::REG_WIDTH, 2);
        write_reg(iirs_pkg::REG_HEIGHT, 2);
        push_load(255);
        push_load(0);
        push_load(255);
        push_load(255);             // closes the frame
        push_query(-128, -128, -128, -128);
        push_query(127, 127, 127, 127);
        push_query(0, 0, 0, 0);
        push_query(1, 1, 1, 1);
        push_query(-1, -1, 2, 2);
        push_query(127, 127, -128, -128);
        push_query(-128, 127, 127, -128);
        push_query(2, 0, 0, 2);
        push_load(0);
        push_load(0);
        push_load(0);
        push_load(0);               // second frame, all dark
        push_query(1, 1, 1, 1);
        push_query(127, -128, -128, 127);
        push_mix(30, 2, 2);
        drain();

        // register values below and above the legal range saturate
        run_phase(0, 1, 20, 20);
        run_phase(100, 2, 10, 30);
        run_phase(2, 127, 10, 10);

        // assorted small images, some without any idling
        repeat (2)
            run_phase(iirs_pkg::dim_t'($urandom_range(2, 9)),
                      iirs_pkg::dim_t'($urandom_range(2, 9)), 10,
                      ($urandom_range(0, 2) == 0) ? 0 : 25);

        // last part: both sides flat out
        run_phase(3, 4, 30, 0);

        repeat (16) @(posedge clk);
        if (expected_sums.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expected_sums.size());
        if (errors == 0 && expected_sums.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
